@@ design/kflc_pkg.sv @@
// ----------------------------------------------------------------------------
// kflc_pkg
// Shared constants, types and helpers for the keyed free-list cache.
// ----------------------------------------------------------------------------
package kflc_pkg;

    localparam int DEPTH       = 64;
    localparam int HANDLE_BITS = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // Operation codes
    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_PUT   = 2'd1;
    localparam logic [1:0] OP_SCHED = 2'd2;

    // Register map (word index)
    localparam logic REG_CAPACITY_LIMIT = 1'b0;
    localparam logic [6:0] CAP_RESET    = 7'd64;

    typedef struct packed {
        logic [31:0]            size;
        logic                   tls;
        logic [HANDLE_BITS-1:0] hnd;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0]             op;
        logic [31:0]            size;
        logic                   tls;
        logic [HANDLE_BITS-1:0] hnd;
    } cmd_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] handle_out;
        logic        stored;
        logic        discard_valid;
        logic [15:0] discard_handle;
    } result_t;

    // 16-bit port handle to internal handle width
    function automatic logic [HANDLE_BITS-1:0] to_hnd(input logic [15:0] h);
        logic [31:0] t;
        t = 32'(h);
        return t[HANDLE_BITS-1:0];
    endfunction

    // internal handle to 16-bit port handle
    function automatic logic [15:0] from_hnd(input logic [HANDLE_BITS-1:0] h);
        logic [31:0] t;
        t = 32'(h);
        return t[15:0];
    endfunction

endpackage

@@ design/keyed_free_list_cache_top.sv @@
// ----------------------------------------------------------------------------
// keyed_free_list_cache_top
// Ordered cache of free task handles keyed by stack size and TLS flag.
// ----------------------------------------------------------------------------
// One word in, one word out. A get (operation 0) walks the cache from the
// front for the first entry whose size and TLS flag match exactly, removes
// it and returns its handle; a plain return (1) stores the handle while the
// entry count is below capacity_limit, otherwise hands it back for discard;
// a scheduler return (2) evicts the front entry when full, then stores.
// Stores are ordered: a new entry goes before the first entry it dominates.
// Operation 3 produces an all-zero result and changes nothing.
// Timing: items are handled one at a time, and every walk visits one entry
// per cycle through the single read port of the entry memory. With N entries
// cached, a get or a storing plain return walks over all N entries, and a
// scheduler return that evicts makes two walks (shift-down over N entries,
// then ordered insert over N-1). A get on an empty cache, a discarding plain
// return and operation 3 skip the walk. The input is taken again as soon as
// the result sits in the output register.
// The entry memory is not cleared at reset; only slots below the count are
// ever read, so no clearing pass is needed. capacity_limit resets to 64 and
// is clamped to the memory depth internally.
// ----------------------------------------------------------------------------
module keyed_free_list_cache_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_stack_bytes,
    input  logic        s_wants_tls,
    input  logic [15:0] s_handle_in,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [15:0] m_handle_out,
    output logic        m_stored,
    output logic        m_discard_valid,
    output logic [15:0] m_discard_handle,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kflc_pkg::*;

    logic [6:0]         cap_reg;
    logic               cfg_wr;
    logic               reg_idx;

    cmd_t               cmd;
    result_t            res;
    logic               res_valid;
    logic               res_ready;

    logic               m_valid_reg;
    result_t            out_reg;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    // --- configuration register ---------------------------------------------
    // paddr[1:0] is the byte offset; paddr[2] picks the word.
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr && (reg_idx == REG_CAPACITY_LIMIT)) begin
            cap_reg <= pwdata[6:0];
        end
    end

    assign prdata = (reg_idx == REG_CAPACITY_LIMIT) ? 32'(cap_reg) : '0;

    // --- command into the sequencer -----------------------------------------
    assign cmd.op   = s_operation;
    assign cmd.size = s_stack_bytes;
    assign cmd.tls  = s_wants_tls;
    assign cmd.hnd  = to_hnd(s_handle_in);

    kflc_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (s_valid),
        .cmd_ready      (s_ready),
        .cmd            (cmd),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .capacity_limit (cap_reg),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    // Entry memory: size, TLS flag and handle packed in one word per slot.
    kflc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // --- output register ----------------------------------------------------
    // Decouples the result channel so the sequencer can take the next word
    // while a finished one still waits downstream.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = out_reg.hit;
    assign m_handle_out     = out_reg.handle_out;
    assign m_stored         = out_reg.stored;
    assign m_discard_valid  = out_reg.discard_valid;
    assign m_discard_handle = out_reg.discard_handle;

endmodule

@@ design/kflc_ram.sv @@
// ----------------------------------------------------------------------------
// kflc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kflc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/kflc_ctrl.sv @@
// ----------------------------------------------------------------------------
// kflc_ctrl
// Sequencer that walks the entry memory: search, remove-with-shift and
// ordered insert-with-carry, one entry per cycle.
// ----------------------------------------------------------------------------
module kflc_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  kflc_pkg::cmd_t                cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output kflc_pkg::result_t             res,
    input  logic [6:0]                    capacity_limit,
    output logic                          mem_we,
    output logic [kflc_pkg::ADDR_W-1:0]   mem_waddr,
    output logic [kflc_pkg::ENTRY_W-1:0]  mem_wdata,
    output logic                          mem_re,
    output logic [kflc_pkg::ADDR_W-1:0]   mem_raddr,
    input  logic [kflc_pkg::ENTRY_W-1:0]  mem_rdata
);
    import kflc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_SHDN = 3'd2;
    localparam logic [2:0] ST_INS  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg,  state_next;
    cmd_t              cmd_reg,    cmd_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic              dv_reg,     dv_next;
    logic [ADDR_W-1:0] dv_idx_reg, dv_idx_next;
    logic [ADDR_W-1:0] rm_pos_reg, rm_pos_next;
    logic              found_reg,  found_next;
    entry_t            carry_reg,  carry_next;
    result_t           res_reg,    res_next;

    logic [CNT_W-1:0]  limit;
    entry_t            rd_entry;
    entry_t            new_entry;
    logic              walking;
    logic              drained;
    logic              match;
    logic              dominates;

    // effective limit: min(capacity_limit, DEPTH)
    always_comb begin
        if (32'(capacity_limit) > 32'(DEPTH)) begin
            limit = CNT_W'(DEPTH);
        end else begin
            limit = CNT_W'(capacity_limit);
        end
    end

    assign rd_entry      = entry_t'(mem_rdata);
    assign new_entry.size = cmd_reg.size;
    assign new_entry.tls  = cmd_reg.tls;
    assign new_entry.hnd  = cmd_reg.hnd;

    assign walking   = (state_reg == ST_SCAN) || (state_reg == ST_SHDN) ||
                       (state_reg == ST_INS);
    assign mem_re    = walking && (rd_ptr_reg < cnt_reg);
    assign mem_raddr = rd_ptr_reg[ADDR_W-1:0];
    assign drained   = !dv_reg && !mem_re;

    assign match     = (rd_entry.size == cmd_reg.size) && (rd_entry.tls == cmd_reg.tls);
    assign dominates = (cmd_reg.size >= rd_entry.size) && (cmd_reg.tls || !rd_entry.tls);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cnt_next    = cnt_reg;
        rd_ptr_next = rd_ptr_reg;
        dv_next     = mem_re;
        dv_idx_next = rd_ptr_reg[ADDR_W-1:0];
        rm_pos_next = rm_pos_reg;
        found_next  = found_reg;
        carry_next  = carry_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;

        if (mem_re) begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next    = cmd;
                    res_next    = '0;
                    rd_ptr_next = '0;
                    found_next  = 1'b0;
                    rm_pos_next = '0;
                    case (cmd.op)
                        OP_GET: begin
                            state_next = (cnt_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        OP_PUT: begin
                            if (cnt_reg < limit) begin
                                res_next.stored = 1'b1;
                                state_next      = ST_INS;
                            end else begin
                                res_next.discard_valid  = 1'b1;
                                res_next.discard_handle = from_hnd(cmd.hnd);
                                state_next              = ST_DONE;
                            end
                        end
                        OP_SCHED: begin
                            res_next.stored = 1'b1;
                            if ((cnt_reg >= limit) && (cnt_reg != '0)) begin
                                // evict the front entry first
                                res_next.discard_valid = 1'b1;
                                state_next             = ST_SHDN;
                            end else begin
                                state_next = ST_INS;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (dv_reg && match) begin
                    res_next.hit        = 1'b1;
                    res_next.handle_out = from_hnd(rd_entry.hnd);
                    rm_pos_next         = dv_idx_reg;
                    state_next          = ST_SHDN;
                end else if (drained) begin
                    state_next = ST_DONE;
                end
            end

            ST_SHDN: begin
                if (dv_reg) begin
                    if (dv_idx_reg == rm_pos_reg) begin
                        // evicted front entry
                        res_next.discard_handle = from_hnd(rd_entry.hnd);
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = dv_idx_reg - ADDR_W'(1);
                        mem_wdata = mem_rdata;
                    end
                end else if (drained) begin
                    cnt_next    = cnt_reg - CNT_W'(1);
                    rd_ptr_next = '0;
                    found_next  = 1'b0;
                    state_next  = (cmd_reg.op == OP_SCHED) ? ST_INS : ST_DONE;
                end
            end

            ST_INS: begin
                if (dv_reg) begin
                    if (found_reg) begin
                        mem_we     = 1'b1;
                        mem_waddr  = dv_idx_reg;
                        mem_wdata  = carry_reg;
                        carry_next = rd_entry;
                    end else if (dominates) begin
                        mem_we     = 1'b1;
                        mem_waddr  = dv_idx_reg;
                        mem_wdata  = new_entry;
                        carry_next = rd_entry;
                        found_next = 1'b1;
                    end
                end else if (drained) begin
                    // tail write: displaced entry, or the new one at the back
                    mem_we     = 1'b1;
                    mem_waddr  = cnt_reg[ADDR_W-1:0];
                    mem_wdata  = found_reg ? carry_reg : new_entry;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dv_reg    <= dv_next;
        end
        cmd_reg    <= cmd_next;
        rd_ptr_reg <= rd_ptr_next;
        dv_idx_reg <= dv_idx_next;
        rm_pos_reg <= rm_pos_next;
        found_reg  <= found_next;
        carry_reg  <= carry_next;
        res_reg    <= res_next;
    end

endmodule

@@ design/kflc_checker.sv @@
// ----------------------------------------------------------------------------
// kflc_checker
// Port-level checks for the keyed free-list cache, bound to the top level.
// ----------------------------------------------------------------------------
module kflc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [15:0] m_handle_out,
    input logic        m_stored,
    input logic        m_discard_valid,
    input logic [15:0] m_discard_handle
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_handle_out) &&
        $stable(m_stored) && $stable(m_discard_valid) && $stable(m_discard_handle))
        else $error("result word changed while stalled");

    // a get hit never stores or discards
    a_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_stored && !m_discard_valid)
        else $error("hit together with store or discard");

    // handle fields are zero when not meaningful
    a_hout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_handle_out == 16'd0)
        else $error("handle_out nonzero without hit");

    a_dh_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_discard_valid |-> m_discard_handle == 16'd0)
        else $error("discard_handle nonzero without discard");

    // items go one at a time: an accepted word blocks the input next cycle
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

endmodule

bind keyed_free_list_cache_top kflc_checker u_kflc_checker (.*);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed free-list cache. A scoreboard class keeps
// its own ordered copy of the cached handles and works out each result word.
// Directed words cover the edge cases. Random phases then run under a range
// of capacity limits, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kflc_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          MAX_CYCLES  = 1_000_000;
    localparam int          HOLD_CYCLES = 300;
    // operation code the block must ignore
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [2:0]  LIMIT_ADDR  = {REG_CAPACITY_LIMIT, 2'b00};
    // stack sizes reused often so that gets find matching entries
    localparam logic [31:0] SIZE_POOL [8] = '{32'd0, 32'hFFFF_FFFF, 32'd4096, 32'd8192,
                                              32'd16384, 32'd65536, 32'h0010_0000,
                                              32'h8000_0000};

    // ------------------------------------------------------------------------
    // Scoreboard: ordered copy of the cache plus the result words still owed.
    // ------------------------------------------------------------------------
    class free_list_scoreboard;
        entry_t     cached[$];      // front of the cache at index 0
        result_t    owed[$];        // expected result words, oldest first
        logic [6:0] limit;
        int         mismatches;

        function new();
            limit      = CAP_RESET;
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction

        function string show(result_t r);
            return $sformatf("hit=%0d handle_out=%h stored=%0d discard=%0d/%h",
                             r.hit, r.handle_out, r.stored, r.discard_valid,
                             r.discard_handle);
        endfunction

        // new entry goes ahead of the first entry it dominates
        function void place(entry_t e);
            int pos;
            pos = 0;
            while (pos < cached.size() &&
                   !(e.size >= cached[pos].size && (e.tls || !cached[pos].tls)))
                pos++;
            if (cached.size() < DEPTH)
                cached.insert(pos, e);
        endfunction

        function void note_word(logic [1:0] op, logic [31:0] size, logic tls,
                                logic [15:0] hnd);
            result_t r;
            entry_t  e;
            int      eff;
            r      = '0;
            eff    = (limit > DEPTH) ? DEPTH : int'(limit);
            e.size = size;
            e.tls  = tls;
            e.hnd  = hnd;
            case (op)
                OP_GET: begin
                    for (int k = 0; k < cached.size(); k++) begin
                        if (cached[k].size == size && cached[k].tls == tls) begin
                            r.hit        = 1'b1;
                            r.handle_out = cached[k].hnd;
                            cached.delete(k);
                            break;
                        end
                    end
                end
                OP_PUT: begin
                    if (cached.size() < eff) begin
                        place(e);
                        r.stored = 1'b1;
                    end else begin
                        r.discard_valid  = 1'b1;
                        r.discard_handle = hnd;
                    end
                end
                OP_SCHED: begin
                    // full cache: front entry goes out first, store always happens
                    if (cached.size() >= eff && cached.size() > 0) begin
                        r.discard_valid  = 1'b1;
                        r.discard_handle = cached[0].hnd;
                        cached.delete(0);
                    end
                    place(e);
                    r.stored = 1'b1;
                end
                default: ;
            endcase
            owed.push_back(r);
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (owed.size() == 0) begin
                flag({"unexpected result word: ", show(got)});
                return;
            end
            want = owed[0];
            owed.delete(0);
            if (got.hit !== want.hit || got.handle_out !== want.handle_out ||
                got.stored !== want.stored || got.discard_valid !== want.discard_valid ||
                got.discard_handle !== want.discard_handle)
                flag({"expected ", show(want), " got ", show(got)});
        endfunction

        function void check_limit(logic [31:0] got);
            if (got !== {25'b0, limit})
                flag($sformatf("capacity_limit read %h, expected %h", got, {25'b0, limit}));
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid, s_ready;
    logic [1:0]  s_operation;
    logic [31:0] s_stack_bytes;
    logic        s_wants_tls;
    logic [15:0] s_handle_in;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_hit, m_stored, m_discard_valid;
    logic [15:0] m_handle_out, m_discard_handle;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    keyed_free_list_cache_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_stack_bytes   (s_stack_bytes),
        .s_wants_tls     (s_wants_tls),
        .s_handle_in     (s_handle_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_handle_out    (m_handle_out),
        .m_stored        (m_stored),
        .m_discard_valid (m_discard_valid),
        .m_discard_handle(m_discard_handle),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    free_list_scoreboard sb = new();

    int words_in  = 0;  // input words accepted so far
    int cycles    = 0;
    bit calm      = 1'b0;  // both sides stop idling while set
    int hold_reqs = 0;     // long receiver stalls asked for
    int holds_run = 0;     // long receiver stalls started
    int hold_left = 0;

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. A result accepted
    // in the same edge as an input always belongs to an older word.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word({m_hit, m_handle_out, m_stored, m_discard_valid, m_discard_handle});
        if (aresetn && s_valid && s_ready) begin
            sb.note_word(s_operation, s_stack_bytes, s_wants_tls, s_handle_in);
            words_in++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("keyed_free_list_cache_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, with an occasional long hold-off counted here
    // so the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_reqs > holds_run) begin
            holds_run++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else if (calm) begin
            m_ready = 1'b1;
        end else begin
            m_ready = ($urandom_range(0, 99) >= 20);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks: every task starts and ends at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_word(logic [1:0] op, logic [31:0] size, logic tls,
                             logic [15:0] hnd);
        int gap;
        int target;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 20)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 5);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_operation   = op;
        s_stack_bytes = size;
        s_wants_tls   = tls;
        s_handle_in   = hnd;
        target        = words_in + 1;
        while (words_in < target) @(negedge aclk);
    endtask

    // wait for every owed word, leaving the block idle
    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // APB write of capacity_limit, then read it back
    task automatic write_limit(logic [6:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = LIMIT_ADDR;
        pwdata  = {25'b0, value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.limit = value;
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.check_limit(prdata);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // random word; gets mostly reuse a key that is in the cache
    task automatic random_word(int get_pct);
        int          r;
        logic [1:0]  op;
        logic [31:0] size;
        logic        tls;
        logic [15:0] hnd;
        entry_t      pick;
        r = $urandom_range(0, 99);
        if (r < get_pct)
            op = OP_GET;
        else if (r < 97)
            op = $urandom_range(0, 1) ? OP_PUT : OP_SCHED;
        else
            op = OP_UNUSED;
        size = ($urandom_range(0, 99) < 15) ? $urandom() : SIZE_POOL[$urandom_range(0, 7)];
        tls  = 1'($urandom_range(0, 1));
        hnd  = 16'($urandom_range(0, 65535));
        if (op == OP_GET && sb.cached.size() > 0 && $urandom_range(0, 99) < 65) begin
            pick = sb.cached[$urandom_range(0, sb.cached.size() - 1)];
            size = pick.size;
            tls  = pick.tls;
        end
        send_word(op, size, tls, hnd);
    endtask

    task automatic run_phase(logic [6:0] lim, int count, int get_pct, bit quiet, bit stall);
        write_limit(lim);
        calm = quiet;
        for (int i = 0; i < count; i++) begin
            if (stall && i == 30)
                hold_reqs++;
            random_word(get_pct);
        end
        drain();
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_operation   = OP_GET;
        s_stack_bytes = '0;
        s_wants_tls   = 1'b0;
        s_handle_in   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: reset limit, ordering, exact-key matching
        send_word(OP_GET,    32'd0,         1'b0, 16'h0000);  // miss on empty cache
        send_word(OP_PUT,    32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_word(OP_PUT,    32'd0,         1'b0, 16'h0000);
        send_word(OP_PUT,    32'd100,       1'b0, 16'h0001);
        send_word(OP_PUT,    32'd100,       1'b1, 16'h0002);  // equal size, flag set
        send_word(OP_SCHED,  32'd100,       1'b0, 16'h0003);  // equal size, flag clear
        send_word(OP_GET,    32'd100,       1'b1, 16'h0000);
        send_word(OP_GET,    32'd100,       1'b0, 16'hFFFF);  // handle ignored on get
        send_word(OP_GET,    32'd7,         1'b1, 16'h0000);  // miss
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);  // no effect, zero result
        send_word(OP_GET,    32'hFFFF_FFFF, 1'b0, 16'h0000);  // size hit, flag miss
        drain();

        // limit lowered below the count: put discards, scheduler return evicts
        write_limit(7'd2);
        send_word(OP_PUT,    32'd5,         1'b1, 16'h1234);
        send_word(OP_SCHED,  32'd5,         1'b1, 16'h4321);
        send_word(OP_GET,    32'd100,       1'b0, 16'h0000);
        drain();

        // zero limit: put always discards, scheduler evicts only when non-empty
        write_limit(7'd0);
        send_word(OP_PUT,    32'd9,         1'b0, 16'hAAAA);
        send_word(OP_SCHED,  32'd9,         1'b0, 16'h5555);
        send_word(OP_GET,    32'd9,         1'b0, 16'h0000);
        send_word(OP_GET,    32'd0,         1'b0, 16'h0000);
        send_word(OP_SCHED,  32'd1,         1'b1, 16'h00FF);  // empty: store, no eviction
        send_word(OP_GET,    32'd1,         1'b1, 16'h0000);
        drain();

        // random phases: limit, words, get percentage, no idling, long stall
        run_phase(7'd64,  120, 25, 1'b0, 1'b1);  // fills up, receiver stall
        run_phase(7'd3,    60, 35, 1'b0, 1'b0);  // far below the count
        run_phase(7'd0,    40, 30, 1'b0, 1'b0);
        run_phase(7'd1,    60, 40, 1'b0, 1'b0);
        run_phase(7'd127, 100, 30, 1'b1, 1'b0);  // above depth, no idling
        run_phase(7'd8,    80, 40, 1'b0, 1'b0);
        run_phase(7'd64,  140, 50, 1'b0, 1'b1);

        // anything arriving now is unexpected
        repeat (300) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("keyed_free_list_cache_top: match");
        end else begin
            $display("keyed_free_list_cache_top: mismatch");
        end
        $finish;
    end

endmodule
